// ===== design/phd_pkg.sv =====
package phd_pkg;

	localparam int unsigned ID_W = 14;
	localparam int unsigned INST_W = 32;
	localparam int unsigned SIZE_W = 24;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;

	localparam logic [0:0] REG_INST_PRESENT = 1'b0;

	localparam logic [2:0] PH_HDR0 = 3'd0;
	localparam logic [2:0] PH_HDR1 = 3'd1;
	localparam logic [2:0] PH_INST = 3'd2;
	localparam logic [2:0] PH_SIZE = 3'd3;
	localparam logic [2:0] PH_PAY = 3'd4;

	localparam logic [1:0] INST_LAST_IDX = 2'd3;

	typedef struct packed {
		logic [ID_W-1:0]   packet_id;
		logic [INST_W-1:0] instance_id;
		logic [SIZE_W-1:0] payload_size;
		logic [BYTE_W-1:0] payload_byte;
		logic              has_data;
		logic              last;
	} phd_result_t;

endpackage

// ===== design/phd_ifs.sv =====
interface phd_byte_if
	import phd_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface phd_result_if
	import phd_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   packet_id;
	logic [INST_W-1:0] instance_id;
	logic [SIZE_W-1:0] payload_size;
	logic [BYTE_W-1:0] payload_byte;
	logic              has_data;
	logic              last;

	modport source (
		output valid, output packet_id, output instance_id, output payload_size,
		output payload_byte, output has_data, output last, input ready
	);
	modport sink (
		input valid, input packet_id, input instance_id, input payload_size,
		input payload_byte, input has_data, input last, output ready
	);
endinterface

// ===== design/phd_parser.sv =====
module phd_parser
	import phd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              inst_present,
	output logic              res_valid,
	output phd_result_t       res
);

	logic [2:0]        phase_q, phase_d;
	logic [1:0]        idx_q, idx_d;
	logic [7:0]        hdr_high_q, hdr_high_d;
	logic [ID_W-1:0]   frame_id_q, frame_id_d;
	logic [1:0]        sfb_q, sfb_d;
	logic [INST_W-1:0] inst_q, inst_d;
	logic [SIZE_W-1:0] size_q, size_d;
	logic [SIZE_W-1:0] left_q, left_d;

	logic              go_after;
	logic              go_begin;
	logic              emit;
	logic [BYTE_W-1:0] emit_byte;
	logic              emit_has;
	logic              emit_last;

	always_comb begin
		phase_d = phase_q;
		idx_d = idx_q;
		hdr_high_d = hdr_high_q;
		frame_id_d = frame_id_q;
		sfb_d = sfb_q;
		inst_d = inst_q;
		size_d = size_q;
		left_d = left_q;
		go_after = 1'b0;
		go_begin = 1'b0;
		emit = 1'b0;
		emit_byte = '0;
		emit_has = 1'b0;
		emit_last = 1'b0;

		unique case (phase_q)
			PH_HDR1: begin
				frame_id_d = {hdr_high_q, data_byte[7:2]};
				sfb_d = data_byte[1:0];
				inst_d = '0;
				size_d = '0;
				idx_d = '0;
				if (inst_present) begin
					phase_d = PH_INST;
				end else begin
					go_after = 1'b1;
				end
			end
			PH_INST: begin
				inst_d = {inst_q[INST_W-BYTE_W-1:0], data_byte};
				if (idx_q == INST_LAST_IDX) begin
					go_after = 1'b1;
				end else begin
					idx_d = idx_q + 2'd1;
				end
			end
			PH_SIZE: begin
				size_d = {size_q[SIZE_W-BYTE_W-1:0], data_byte};
				idx_d = idx_q + 2'd1;
				if (idx_d >= sfb_q) begin
					go_begin = 1'b1;
				end
			end
			PH_PAY: begin
				left_d = left_q - SIZE_W'(1);
				emit = 1'b1;
				emit_byte = data_byte;
				emit_has = 1'b1;
				emit_last = (left_d == '0);
				if (left_d == '0) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				hdr_high_d = data_byte;
				phase_d = PH_HDR1;
			end
		endcase

		if (go_after) begin
			idx_d = '0;
			if (sfb_d == 2'd0) begin
				go_begin = 1'b1;
			end else begin
				phase_d = PH_SIZE;
			end
		end

		if (go_begin) begin
			idx_d = '0;
			if (size_d == '0) begin
				emit = 1'b1;
				emit_last = 1'b1;
				phase_d = PH_HDR0;
			end else begin
				left_d = size_d;
				phase_d = PH_PAY;
			end
		end
	end

	assign res_valid = accept & emit;
	assign res.packet_id = frame_id_d;
	assign res.instance_id = inst_d;
	assign res.payload_size = size_d;
	assign res.payload_byte = emit_byte;
	assign res.has_data = emit_has;
	assign res.last = emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			idx_q <= '0;
			hdr_high_q <= '0;
			frame_id_q <= '0;
			sfb_q <= '0;
			inst_q <= '0;
			size_q <= '0;
			left_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			idx_q <= idx_d;
			hdr_high_q <= hdr_high_d;
			frame_id_q <= frame_id_d;
			sfb_q <= sfb_d;
			inst_q <= inst_d;
			size_q <= size_d;
			left_q <= left_d;
		end
	end

endmodule

// ===== design/packet_header_deframer_unit.sv =====
// Each accepted byte is parsed in the cycle it arrives; its result, if any, appears
// in the output register in the next cycle.
// Throughput is one byte per cycle; input is taken whenever the output register is
// empty or is being drained in the same cycle.
// Asynchronous active-low reset returns the parser to the first header byte, clears
// all frame state and the output register, and clears instance_id_present.
module packet_header_deframer_unit
	import phd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	phd_byte_if.sink              byte_in,
	phd_result_if.source          result_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic        inst_present_q;
	logic        out_valid_q;
	phd_result_t out_q;
	logic        accept;
	logic        res_valid;
	phd_result_t res;
	logic        cfg_hit;

	assign pready = 1'b1;
	assign cfg_hit = (paddr[2] == REG_INST_PRESENT);
	assign prdata = cfg_hit ? APB_DATA_W'(inst_present_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inst_present_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && cfg_hit) begin
			inst_present_q <= pwdata[0];
		end
	end

	assign byte_in.ready = !out_valid_q || result_out.ready;
	assign accept = byte_in.valid && byte_in.ready;

	phd_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (byte_in.data_byte),
		.inst_present (inst_present_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (res_valid) begin
			out_q <= res;
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.packet_id = out_q.packet_id;
	assign result_out.instance_id = out_q.instance_id;
	assign result_out.payload_size = out_q.payload_size;
	assign result_out.payload_byte = out_q.payload_byte;
	assign result_out.has_data = out_q.has_data;
	assign result_out.last = out_q.last;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import phd_pkg::*;

	localparam logic [APB_ADDR_W-1:0] INST_CFG_ADDR = APB_ADDR_W'(4 * REG_INST_PRESENT);

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	phd_byte_if byte_if ();
	phd_result_if res_if ();

	packet_header_deframer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(byte_if),
		.result_out(res_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	phd_result_t pending_results[$];
	int mismatch_count = 0;
	int unsigned bytes_sent = 0;
	int hold_cycles = 0;
	bit src_idle = 1'b1;
	bit snk_idle = 1'b1;

	bit inst_cfg = 1'b0;
	logic [2:0] ph = PH_HDR0;
	logic [1:0] byte_idx = '0;
	logic [BYTE_W-1:0] hdr_hi = '0;
	logic [ID_W-1:0] cur_id = '0;
	logic [1:0] size_len = '0;
	logic [INST_W-1:0] cur_inst = '0;
	logic [SIZE_W-1:0] cur_size = '0;
	logic [SIZE_W-1:0] remaining = '0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int pick_gap(input bit en);
		int r;
		r = $urandom_range(0, 99);
		if (!en || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic string fmt_result(input phd_result_t r);
		return $sformatf("id=%h inst=%h size=%h byte=%h has_data=%b last=%b",
			r.packet_id, r.instance_id, r.payload_size, r.payload_byte, r.has_data, r.last);
	endfunction

	function automatic void log_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endfunction

	function automatic void expect_result(input phd_result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic void open_payload();
		byte_idx = '0;
		if (cur_size == '0) begin
			expect_result('{cur_id, cur_inst, cur_size, 8'h00, 1'b0, 1'b1});
			ph = PH_HDR0;
		end else begin
			remaining = cur_size;
			ph = PH_PAY;
		end
	endfunction

	function automatic void close_prefix();
		byte_idx = '0;
		if (size_len == '0)
			open_payload();
		else
			ph = PH_SIZE;
	endfunction

	function automatic void parse_byte(input logic [BYTE_W-1:0] b);
		case (ph)
			PH_HDR1: begin
				cur_id = {hdr_hi, b[7:2]};
				size_len = b[1:0];
				cur_inst = '0;
				cur_size = '0;
				byte_idx = '0;
				if (inst_cfg)
					ph = PH_INST;
				else
					close_prefix();
			end
			PH_INST: begin
				cur_inst = {cur_inst[INST_W-9:0], b};
				if (byte_idx == INST_LAST_IDX)
					close_prefix();
				else
					byte_idx++;
			end
			PH_SIZE: begin
				cur_size = {cur_size[SIZE_W-9:0], b};
				byte_idx++;
				if (byte_idx >= size_len)
					open_payload();
			end
			PH_PAY: begin
				remaining--;
				expect_result('{cur_id, cur_inst, cur_size, b, 1'b1,
					remaining == '0});
				if (remaining == '0)
					ph = PH_HDR0;
			end
			default: begin
				hdr_hi = b;
				ph = PH_HDR1;
			end
		endcase
	endfunction

	always @(posedge clk) begin : monitor
		phd_result_t got;
		phd_result_t want;
		if (res_if.valid && res_if.ready) begin
			got = '{res_if.packet_id, res_if.instance_id, res_if.payload_size,
				res_if.payload_byte, res_if.has_data, res_if.last};
			if (pending_results.size() == 0) begin
				log_mismatch({"unexpected result ", fmt_result(got)});
			end else begin
				want = pending_results.pop_front();
				if (got.packet_id !== want.packet_id || got.instance_id !== want.instance_id ||
					got.payload_size !== want.payload_size ||
					got.payload_byte !== want.payload_byte ||
					got.has_data !== want.has_data || got.last !== want.last)
					log_mismatch({"expected ", fmt_result(want), " got ", fmt_result(got)});
			end
		end
		if (byte_if.valid && byte_if.ready)
			parse_byte(byte_if.data_byte);
	end

	initial begin : result_drain
		int stall;
		stall = 0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				res_if.ready <= 1'b0;
				hold_cycles--;
			end else if (stall > 0) begin
				res_if.ready <= 1'b0;
				stall--;
			end else begin
				res_if.ready <= 1'b1;
				stall = pick_gap(snk_idle);
			end
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		byte_if.valid <= 1'b1;
		byte_if.data_byte <= b;
		do @(posedge clk); while (!byte_if.ready);
		bytes_sent++;
		gap = pick_gap(src_idle);
		if (gap > 0) begin
			byte_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		byte_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_inst_cfg(input bit v);
		logic [APB_DATA_W-1:0] rd;
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= INST_CFG_ADDR;
		pwdata <= APB_DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		inst_cfg = v;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== APB_DATA_W'(v))
			log_mismatch($sformatf("register readback expected %h got %h", APB_DATA_W'(v), rd));
	endtask

	task automatic send_frame(input logic [ID_W-1:0] id, input logic [1:0] len,
		input logic [INST_W-1:0] inst, input logic [SIZE_W-1:0] size, input int npay);
		send_byte(id[ID_W-1:6]);
		send_byte({id[5:0], len});
		if (inst_cfg) begin
			for (int i = 3; i >= 0; i--)
				send_byte(inst[8*i +: 8]);
		end
		for (int i = int'(len) - 1; i >= 0; i--)
			send_byte(size[8*i +: 8]);
		repeat (npay) send_byte(8'($urandom));
	endtask

	task automatic test_empty_frames();
		set_inst_cfg(1'b0);
		send_frame(14'h3FFF, 2'd0, '0, '0, 0);
		send_frame(14'h0000, 2'd1, '0, '0, 0);
		send_frame(14'h2AAA, 2'd3, '0, '0, 0);
		set_inst_cfg(1'b1);
		send_frame(14'h1555, 2'd0, 32'hFFFF_FFFF, '0, 0);
		send_frame(14'h0F0F, 2'd2, 32'h0000_0000, '0, 0);
	endtask

	task automatic test_size_fields();
		set_inst_cfg(1'b0);
		send_byte(8'h00);
		send_byte({6'h3F, 2'd1});
		send_byte(8'd2);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_frame(14'h0123, 2'd2, '0, 24'h000003, 3);
		send_frame(14'h3FFE, 2'd3, '0, 24'h000001, 1);
	endtask

	task automatic test_instance_id();
		set_inst_cfg(1'b1);
		send_frame(14'h0001, 2'd1, 32'h8000_0001, 24'd2, 2);
		send_frame(14'h2000, 2'd3, 32'h7FFF_FFFE, 24'd1, 1);
	endtask

	task automatic test_midframe_config();
		set_inst_cfg(1'b1);
		send_byte(8'h12);
		set_inst_cfg(1'b0);
		send_byte({6'h0D, 2'd1});
		send_byte(8'd1);
		send_byte(8'hC3);
		set_inst_cfg(1'b1);
		send_byte(8'hA5);
		send_byte({6'h15, 2'd0});
		send_byte(8'hDE);
		send_byte(8'hAD);
		set_inst_cfg(1'b0);
		send_byte(8'hBE);
		send_byte(8'hEF);
	endtask

	task automatic test_backpressure();
		set_inst_cfg(1'b0);
		src_idle = 1'b0;
		hold_cycles = 200;
		send_frame(14'h2468, 2'd1, '0, 24'd30, 30);
		wait_idle();
		src_idle = 1'b1;
	endtask

	task automatic test_random_frames();
		int unsigned goal;
		logic [1:0] len;
		logic [SIZE_W-1:0] size;
		int r;
		for (int p = 0; p < 4; p++) begin
			set_inst_cfg(bit'(p % 2));
			src_idle = (p != 2);
			snk_idle = (p != 2);
			goal = bytes_sent + 120;
			while (bytes_sent < goal) begin
				len = 2'($urandom_range(0, 3));
				r = $urandom_range(0, 99);
				if (len == 2'd0 || r < 15)
					size = '0;
				else if (r < 92)
					size = SIZE_W'($urandom_range(1, 12));
				else
					size = SIZE_W'($urandom_range(13, 60));
				send_frame(14'($urandom), len, $urandom, size, int'(size));
				if ($urandom_range(0, 19) == 0)
					wait_idle();
			end
		end
		src_idle = 1'b1;
		snk_idle = 1'b1;
	endtask

	task automatic test_oversized_frame();
		set_inst_cfg(1'b1);
		send_frame(14'h3FFF, 2'd3, $urandom, 24'hFFFFFF, 40);
	endtask

	initial begin
		byte_if.valid <= 1'b0;
		byte_if.data_byte <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_frames();
		test_size_fields();
		test_instance_id();
		test_midframe_config();
		test_backpressure();
		test_random_frames();
		test_oversized_frame();
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/phd_pkg.sv
design/phd_ifs.sv
design/phd_parser.sv
design/packet_header_deframer_unit.sv
verif/tb.sv
